FILE: design/rsd_pkg.sv
// Shared types and constants for the record stream deframer.
// No dependencies; imported by every module of the block.
package rsd_pkg;

  // Result kinds
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAY = 2'd1;
  localparam logic [1:0] KIND_ERR = 2'd2;
  localparam logic [1:0] KIND_END = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_RSV  = 2'd1;
  localparam logic [1:0] ERR_CONT = 2'd2;

  // Halt status
  localparam logic [1:0] HALT_RUN = 2'd0;
  localparam logic [1:0] HALT_ERR = 2'd1;
  localparam logic [1:0] HALT_END = 2'd2;

  // Header positions of interest; PAYLOAD means inside the record body
  localparam logic [3:0] HP_LEN_HI  = 4'd1;
  localparam logic [3:0] HP_CNT_HI  = 4'd7;
  localparam logic [3:0] HP_PAYLOAD = 4'd8;

  localparam logic [15:0] HDR_BYTES      = 16'd8;
  localparam logic [31:0] COUNT_RSV_MASK = 32'hffff_fffc;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef struct packed {
    logic       resync;
    logic [7:0] data;
  } rsd_item_t;

endpackage

FILE: design/rsd_front.sv
// Input stage: registers each incoming beat and classifies it as resync or file byte.
// Depends on rsd_pkg.
module rsd_front
  import rsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_req,
  input  logic [7:0] in_byte,
  output logic      out_valid,
  input  logic      out_ready,
  output rsd_item_t out_item
);

  logic      valid_r;
  rsd_item_t item_r;

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_item  = item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  // drop the data byte of a resync so the back end never sees stale bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.resync <= in_req;
      item_r.data   <= in_req ? 8'd0 : in_byte;
    end
  end

endmodule

FILE: design/rsd_queue.sv
// Short register queue that decouples the classifying front from the deframing back.
// Depends on rsd_pkg.
module rsd_queue
  import rsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  rsd_item_t in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output rsd_item_t out_item
);

  rsd_item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r;
  logic [QPTR_W-1:0]     rd_ptr_r;
  logic [QCNT_W-1:0]     count_r;
  logic                  push;
  logic                  pop;

  assign in_ready  = count_r != QCNT_W'(QUEUE_DEPTH);
  assign out_valid = count_r != '0;
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
    ptr_inc = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop)  rd_ptr_r <= ptr_inc(rd_ptr_r);
      if (push && !pop) begin
        count_r <= count_r + QCNT_W'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= in_item;
  end

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue count did not advance on push");

  a_head_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> $stable(out_item))
    else $error("queue head changed while stalled");

endmodule

FILE: design/rsd_back.sv
// Deframing engine: header parsing, payload pass-through, halt handling, output register.
// Depends on rsd_pkg.
module rsd_back
  import rsd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       q_valid,
  output logic       q_ready,
  input  rsd_item_t  q_item,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_payload,
  output logic       out_start,
  output logic [1:0] out_err
);

  logic [3:0]  hdr_pos_r,    hdr_pos_nxt;
  logic [7:0]  held_r,       held_nxt;
  logic [15:0] rec_len_r,    rec_len_nxt;
  logic [14:0] pay_left_r,   pay_left_nxt;
  logic        cont_next_r,  cont_next_nxt;
  logic        first_pend_r, first_pend_nxt;
  logic        fresh_r,      fresh_nxt;
  logic [1:0]  halt_r,       halt_nxt;
  logic [1:0]  herr_r,       herr_nxt;

  logic        out_valid_r;
  logic [1:0]  out_kind_r;
  logic [7:0]  out_payload_r;
  logic        out_start_r;
  logic [1:0]  out_err_r;

  logic [1:0]  res_kind;
  logic [7:0]  res_payload;
  logic        res_start;
  logic [1:0]  res_err;

  logic        pop;
  logic [15:0] word;
  logic [31:0] word_ext;
  logic [15:0] body_len;

  assign q_ready     = !out_valid_r || out_ready;
  assign pop         = q_valid && q_ready;
  assign out_valid   = out_valid_r;
  assign out_kind    = out_kind_r;
  assign out_payload = out_payload_r;
  assign out_start   = out_start_r;
  assign out_err     = out_err_r;

  assign word     = {q_item.data, held_r};
  assign word_ext = {{16{word[15]}}, word};
  assign body_len = rec_len_r - HDR_BYTES;

  always_comb begin
    hdr_pos_nxt    = hdr_pos_r;
    held_nxt       = held_r;
    rec_len_nxt    = rec_len_r;
    pay_left_nxt   = pay_left_r;
    cont_next_nxt  = cont_next_r;
    first_pend_nxt = first_pend_r;
    fresh_nxt      = fresh_r;
    halt_nxt       = halt_r;
    herr_nxt       = herr_r;
    res_kind       = KIND_HDR;
    res_payload    = 8'd0;
    res_start      = 1'b0;
    res_err        = ERR_NONE;

    priority if (q_item.resync) begin
      hdr_pos_nxt    = '0;
      held_nxt       = '0;
      pay_left_nxt   = '0;
      cont_next_nxt  = 1'b0;
      first_pend_nxt = 1'b0;
      fresh_nxt      = 1'b0;
      halt_nxt       = HALT_RUN;
      herr_nxt       = ERR_NONE;
    end else if (halt_r == HALT_ERR) begin
      res_kind = KIND_ERR;
      res_err  = herr_r;
    end else if (halt_r != HALT_RUN) begin
      res_kind = KIND_END;
    end else if (hdr_pos_r[3]) begin
      res_kind       = KIND_PAY;
      res_payload    = q_item.data;
      res_start      = first_pend_r && fresh_r;
      first_pend_nxt = 1'b0;
      pay_left_nxt   = pay_left_r - 15'd1;
      if (pay_left_nxt == '0) hdr_pos_nxt = '0;
    end else if (!hdr_pos_r[0]) begin
      held_nxt    = q_item.data;
      hdr_pos_nxt = hdr_pos_r + 4'd1;
    end else if (hdr_pos_r == HP_LEN_HI) begin
      rec_len_nxt = word;
      if (word[15]) begin
        // negative length: end of file marker
        halt_nxt = HALT_END;
        herr_nxt = ERR_NONE;
        res_kind = KIND_END;
      end else begin
        hdr_pos_nxt = hdr_pos_r + 4'd1;
      end
    end else if (hdr_pos_r == HP_CNT_HI) begin
      if ((word_ext & COUNT_RSV_MASK) != '0) begin
        halt_nxt = HALT_ERR;
        herr_nxt = ERR_RSV;
        res_kind = KIND_ERR;
        res_err  = ERR_RSV;
      end else if (word[1] != cont_next_r) begin
        halt_nxt = HALT_ERR;
        herr_nxt = ERR_CONT;
        res_kind = KIND_ERR;
        res_err  = ERR_CONT;
      end else begin
        cont_next_nxt  = word[0];
        fresh_nxt      = !word[1];
        first_pend_nxt = 1'b1;
        if (rec_len_r > HDR_BYTES) begin
          pay_left_nxt = body_len[14:0];
          hdr_pos_nxt  = HP_PAYLOAD;
        end else begin
          // empty body: go straight to the next header
          pay_left_nxt = '0;
          hdr_pos_nxt  = '0;
        end
      end
    end else begin
      hdr_pos_nxt = hdr_pos_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hdr_pos_r    <= '0;
      held_r       <= '0;
      rec_len_r    <= '0;
      pay_left_r   <= '0;
      cont_next_r  <= 1'b0;
      first_pend_r <= 1'b0;
      fresh_r      <= 1'b0;
      halt_r       <= HALT_RUN;
      herr_r       <= ERR_NONE;
    end else if (pop) begin
      hdr_pos_r    <= hdr_pos_nxt;
      held_r       <= held_nxt;
      rec_len_r    <= rec_len_nxt;
      pay_left_r   <= pay_left_nxt;
      cont_next_r  <= cont_next_nxt;
      first_pend_r <= first_pend_nxt;
      fresh_r      <= fresh_nxt;
      halt_r       <= halt_nxt;
      herr_r       <= herr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (q_ready) begin
      out_valid_r <= q_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_kind_r    <= res_kind;
      out_payload_r <= res_payload;
      out_start_r   <= res_start;
      out_err_r     <= res_err;
    end
  end

  a_payload_pos: assert property (@(posedge clk) disable iff (!rst_n)
    hdr_pos_r[3] |-> (hdr_pos_r[2:0] == 3'd0 && pay_left_r != '0))
    else $error("payload mode with bad position or empty count");

  a_resync_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && q_item.resync) |=> (halt_r == HALT_RUN && hdr_pos_r == '0 && !cont_next_r))
    else $error("resync did not clear deframer state");

  a_halt_answer: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !q_item.resync && halt_r == HALT_ERR)
      |=> (out_valid_r && out_kind_r == KIND_ERR && out_err_r == $past(herr_r)))
    else $error("halted block did not repeat its error");

  a_err_means_halt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_err_r != ERR_NONE) |-> halt_r == HALT_ERR)
    else $error("error reported while not halted on error");

endmodule

FILE: design/record_stream_deframer.sv
// Top level of the record stream deframer: input stage, queue and deframing engine.
// Depends on rsd_pkg, rsd_front, rsd_queue and rsd_back.
//
// Feed raw file bytes (in_tuser = 0) or a resync request (in_tuser = 1) one beat at a
// time; every input beat produces exactly one output beat, in order. The block takes a
// beat every cycle and delivers one per cycle when out_tready stays high; the deframing
// engine updates its header counters and payload count once per beat, which sets that
// one-beat-per-cycle figure. Input passes through the input register, the two-entry
// queue and the output register. After reset the block expects the first
// header byte. An error or an end marker halts it; every following byte is answered
// with the halt kind until a resync beat arrives.
module record_stream_deframer
  import rsd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] raw_byte
  input  logic [0:0]  in_tuser,   // [0] req_type
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] payload_byte, [9:8] error_code, [15:10] zero
  output logic [2:0]  out_tuser   // [1:0] out_kind, [2] logical_start
);

  logic       f_valid;
  logic       f_ready;
  rsd_item_t  f_item;
  logic       q_valid;
  logic       q_ready;
  rsd_item_t  q_item;
  logic [1:0] b_kind;
  logic [7:0] b_payload;
  logic       b_start;
  logic [1:0] b_err;

  rsd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_req    (in_tuser[0]),
    .in_byte   (in_tdata),
    .out_valid (f_valid),
    .out_ready (f_ready),
    .out_item  (f_item)
  );

  rsd_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  rsd_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_item      (q_item),
    .out_valid   (out_tvalid),
    .out_ready   (out_tready),
    .out_kind    (b_kind),
    .out_payload (b_payload),
    .out_start   (b_start),
    .out_err     (b_err)
  );

  assign out_tdata = {6'd0, b_err, b_payload};
  assign out_tuser = {b_start, b_kind};

endmodule

FILE: dv/testbench.sv
`timescale 1ns / 100ps
// Self-checking testbench for record_stream_deframer: drives raw bytes and resync beats,
// predicts every output beat and compares it field by field. Depends on rsd_pkg and the RTL.
module testbench;
  import rsd_pkg::*;

  localparam int BEAT_TARGET  = 1550;
  localparam int HOLD_CYCLES  = 300;
  localparam int QUIET_LIMIT  = 2000;
  localparam int SETTLE_TICKS = 8;
  localparam int MAX_REPORTS  = 40;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] data;
    logic       start;
    logic [1:0] err;
  } out_beat_t;

  class deframe_scoreboard;
    out_beat_t   expected_beats[$];
    int          failures;
    int          checked;
    logic [3:0]  hdr_pos;
    logic [7:0]  low_byte;
    logic [15:0] rec_len;
    logic [14:0] body_left;
    bit          more_follows;
    bit          first_pending;
    bit          fresh_rec;
    logic [1:0]  halt_state;
    logic [1:0]  halt_code;

    function new();
      failures      = 0;
      checked       = 0;
      hdr_pos       = '0;
      low_byte      = '0;
      rec_len       = '0;
      body_left     = '0;
      more_follows  = 1'b0;
      first_pending = 1'b0;
      fresh_rec     = 1'b0;
      halt_state    = HALT_RUN;
      halt_code     = ERR_NONE;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function void report(string msg);
      failures++;
      if (failures <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endfunction

    // Advance the deframer state by one accepted input beat and queue its answer.
    function void note_input(bit resync, logic [7:0] b);
      out_beat_t   r;
      logic [15:0] word;
      r.kind  = KIND_HDR;
      r.data  = 8'h00;
      r.start = 1'b0;
      r.err   = ERR_NONE;
      word    = {b, low_byte};
      if (resync) begin
        hdr_pos       = '0;
        low_byte      = '0;
        body_left     = '0;
        more_follows  = 1'b0;
        first_pending = 1'b0;
        fresh_rec     = 1'b0;
        halt_state    = HALT_RUN;
        halt_code     = ERR_NONE;
      end else if (halt_state == HALT_ERR) begin
        r.kind = KIND_ERR;
        r.err  = halt_code;
      end else if (halt_state != HALT_RUN) begin
        r.kind = KIND_END;
      end else if (hdr_pos >= HP_PAYLOAD) begin
        r.kind        = KIND_PAY;
        r.data        = b;
        r.start       = first_pending & fresh_rec;
        first_pending = 1'b0;
        body_left     = body_left - 15'd1;
        if (body_left == '0) hdr_pos = '0;
      end else if (!hdr_pos[0]) begin
        low_byte = b;
        hdr_pos  = hdr_pos + 4'd1;
      end else if (hdr_pos == HP_LEN_HI) begin
        rec_len = word;
        if (word[15]) begin
          halt_state = HALT_END;
          halt_code  = ERR_NONE;
          r.kind     = KIND_END;
        end else begin
          hdr_pos = hdr_pos + 4'd1;
        end
      end else if (hdr_pos == HP_CNT_HI) begin
        // Reserved bits win over the continuation check; a set sign bit counts as reserved.
        if (word[15:2] != '0) begin
          halt_state = HALT_ERR;
          halt_code  = ERR_RSV;
          r.kind     = KIND_ERR;
          r.err      = ERR_RSV;
        end else if (word[1] != more_follows) begin
          halt_state = HALT_ERR;
          halt_code  = ERR_CONT;
          r.kind     = KIND_ERR;
          r.err      = ERR_CONT;
        end else begin
          more_follows  = word[0];
          fresh_rec     = !word[1];
          first_pending = 1'b1;
          if (rec_len > HDR_BYTES) begin
            body_left = 15'(rec_len - HDR_BYTES);
            hdr_pos   = HP_PAYLOAD;
          end else begin
            body_left = '0;
            hdr_pos   = '0;
          end
        end
      end else begin
        hdr_pos = hdr_pos + 4'd1;
      end
      expected_beats.push_back(r);
    endfunction

    function void check_output(logic [15:0] tdata, logic [2:0] tuser);
      out_beat_t want;
      if (expected_beats.size() == 0) begin
        report($sformatf("output beat %0d with nothing expected (tdata %h tuser %h)",
                         checked, tdata, tuser));
      end else begin
        want = expected_beats.pop_front();
        if (tuser[1:0] !== want.kind)
          report($sformatf("beat %0d kind %h, want %h", checked, tuser[1:0], want.kind));
        if (tdata[7:0] !== want.data)
          report($sformatf("beat %0d payload %h, want %h", checked, tdata[7:0], want.data));
        if (tuser[2] !== want.start)
          report($sformatf("beat %0d logical start %b, want %b", checked, tuser[2], want.start));
        if (tdata[9:8] !== want.err)
          report($sformatf("beat %0d error code %h, want %h", checked, tdata[9:8], want.err));
        if (tdata[15:10] !== 6'd0)
          report($sformatf("beat %0d padding %h not zero", checked, tdata[15:10]));
      end
      checked++;
    endfunction
  endclass

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata   = 8'h00;
  logic [0:0]  in_tuser   = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [2:0]  out_tuser;

  deframe_scoreboard board;
  bit jitter_on    = 1'b1;
  bit hold_request = 1'b0;
  bit chain_open   = 1'b0;
  int beats_sent   = 0;

  record_stream_deframer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_tvalid && in_tready) board.note_input(in_tuser[0], in_tdata);
      if (out_tvalid && out_tready) board.check_output(out_tdata, out_tuser);
    end
  end

  // Output side: random back-pressure, plus one long hold when asked.
  initial begin : sink
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        out_tready <= !(jitter_on && $urandom_range(99) < 10);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("Test completed with failures");
    $finish;
  end

  task automatic send_beat(input bit resync, input logic [7:0] b);
    if (jitter_on && $urandom_range(99) < 4) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= resync;
    in_tdata  <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
  endtask

  task automatic send_resync();
    send_beat(1'b1, 8'($urandom));
    chain_open = 1'b0;
  endtask

  task automatic send_word(input logic [15:0] w);
    send_beat(1'b0, w[7:0]);
    send_beat(1'b0, w[15:8]);
  endtask

  task automatic send_header(input logic [15:0] len, input logic [15:0] cnt);
    send_word(len);
    send_word(16'($urandom));
    send_word(16'($urandom));
    send_word(cnt);
  endtask

  task automatic send_record(input logic [15:0] len, input bit tbc);
    send_header(len, {14'd0, chain_open, tbc});
    if (len > HDR_BYTES) repeat (int'(len) - 8) send_beat(1'b0, 8'($urandom));
    chain_open = tbc;
  endtask

  // Feed up to three bytes into a halted block, then clear it.
  task automatic send_halted_tail();
    repeat ($urandom_range(3)) send_beat(1'b0, 8'($urandom));
    send_resync();
  endtask

  initial begin : stimulus
    int          pick;
    int          target;
    logic [15:0] len;
    logic [15:0] cnt;
    bit          drained;
    bit          held;
    board      = new();
    target     = BEAT_TARGET;
    drained    = 1'b0;
    held       = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: first record with a one-byte body, end marker, reserved-bit error.
    send_header(16'd9, 16'h0001);
    send_beat(1'b0, 8'hff);
    chain_open = 1'b1;
    send_word(16'h8000);
    send_beat(1'b0, 8'h00);
    send_resync();
    send_header(16'd0, 16'h8000);
    send_beat(1'b0, 8'hff);
    send_resync();

    while (beats_sent < target) begin
      jitter_on = !(beats_sent >= 600 && beats_sent < 900);
      if (!drained && beats_sent >= 300) begin
        drained = 1'b1;
        in_tvalid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0) @(posedge clk);
      end
      if (!held && beats_sent >= 1100) begin
        held = 1'b1;
        hold_request = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 66) begin
        pick = $urandom_range(99);
        if (pick < 25) len = 16'($urandom_range(8));
        else if (pick < 90) len = 16'($urandom_range(40, 9));
        else len = 16'($urandom_range(255, 41));
        send_record(len, 1'($urandom));
      end else if (pick < 72) begin
        cnt = 16'($urandom) | (16'h0004 << $urandom_range(13));
        send_header(16'($urandom_range(40)), cnt);
        send_halted_tail();
      end else if (pick < 78) begin
        cnt = {14'd0, !chain_open, 1'($urandom)};
        send_header(16'($urandom_range(40)), cnt);
        send_halted_tail();
      end else if (pick < 83) begin
        send_word(16'($urandom) | 16'h8000);
        send_halted_tail();
      end else if (pick < 88) begin
        // Cut a record short somewhere in its header or body.
        repeat ($urandom_range(12, 1)) send_beat(1'b0, 8'($urandom));
        send_resync();
      end else if (pick < 94) begin
        send_resync();
      end else begin
        repeat ($urandom_range(20, 1)) send_beat(1'b0, 8'($urandom));
        send_resync();
      end
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_TICKS) @(posedge clk);
    if (board.failures == 0 && board.pending() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
